[rtl/l2p_pkg.sv]
// l2p_pkg: shared constants, coefficient table and pipeline control type
// for the four-lane polynomial log2 block. No dependencies.
package l2p_pkg;

  // lane count and fixed-point format of the result
  localparam int LANES       = 4;
  localparam int FRAC_BITS   = 24;

  // single-precision field layout
  localparam int X_W         = 32;
  localparam int MANT_W      = 23;
  localparam int M_W         = MANT_W + 1;
  localparam int EXP_W       = 8;
  localparam int EXPO_W      = EXP_W + 1;
  localparam int EXP_BIAS    = 127;
  localparam logic [EXP_W-1:0] EXP_ALL_ONES = '1;

  // result width on the output bus
  localparam int OUT_W       = 33;

  // polynomial datapath widths: |p| stays below 4, plus sign and margin
  localparam int COEF_Q      = 30;
  localparam int DEGREE      = 5;
  localparam int P_W         = FRAC_BITS + 4;
  localparam int PROD_W      = P_W + M_W + 1;
  localparam int FPROD_W     = P_W + M_W;

  // one decode stage, a multiply and a round/add stage per product
  localparam int LANE_STAGES = 2 * DEGREE + 3;
  localparam int PIPE_DEPTH  = LANE_STAGES + 1;

  // stream bus widths, padded to whole bytes
  localparam int IN_DW       = ((LANES * X_W + 7) / 8) * 8;
  localparam int OUT_DW      = ((LANES * OUT_W + 7) / 8) * 8;

  // coefficients c0..c5 in Q30
  localparam logic signed [63:0] COEF_Q30 [DEGREE+1] = '{
    64'sd3345553930,
    -64'sd3569331498,
    64'sd2790488785,
    -64'sd1322345591,
    64'sd341679004,
    -64'sd36975380
  };

  // coefficient k brought to FRAC_BITS, round half up
  function automatic logic signed [P_W-1:0] coef(input int k);
    logic signed [63:0] v;
    int                 sh;
    sh = COEF_Q - FRAC_BITS;
    v  = COEF_Q30[k];
    if (sh > 0) begin
      v = (v + (64'sd1 <<< (sh - 1))) >>> sh;
    end
    return P_W'(v);
  endfunction

  // per-stage load enables from the flow control to the lanes
  typedef struct packed {
    logic [PIPE_DEPTH-1:0] en;
  } pipe_ctl_t;

endpackage

[rtl/log2_poly_approx_4lane.sv]
// log2_poly_approx_4lane: top level; flow control, four lanes and the
// output register that merges the lane results. Depends on l2p_pkg,
// l2p_ctrl and l2p_lane.
//
//   channel | dir | tdata                                   | tuser
//   s_*     | in  | x_lane0..x_lane3, 32 bits each           | -
//   m_*     | out | log_lane0..log_lane3, 33 bits each, pad | neg_inf_lane0..3
//
// One request per cycle when the output is taken every cycle.
// A request passes a decode stage, six multiplies each followed by a
// round/add stage, and the merging output register.
// rst clears only the valid bits; the datapath registers are not reset.
// On a stall ready ripples back stage by stage, so empty stages still fill
// while a finished result waits at the output.
module log2_poly_approx_4lane (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [l2p_pkg::IN_DW-1:0]   s_tdata,   // x_lane0 .. x_lane3
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [l2p_pkg::OUT_DW-1:0]  m_tdata,   // log_lane0 .. log_lane3, zero pad
  output logic [l2p_pkg::LANES-1:0]   m_tuser    // neg_inf_lane0 .. neg_inf_lane3
);

  l2p_pkg::pipe_ctl_t ctl;

  // flow control
  l2p_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .ctl      (ctl)
  );

  logic [l2p_pkg::OUT_DW-1:0] data_next;
  logic [l2p_pkg::LANES-1:0]  user_next;

  // lanes
  for (genvar l = 0; l < l2p_pkg::LANES; l++) begin : g_lane
    logic signed [l2p_pkg::OUT_W-1:0] lane_log;
    logic                             lane_neg;

    l2p_lane u_lane (
      .clk     (clk),
      .ctl     (ctl),
      .x       (s_tdata[l*l2p_pkg::X_W +: l2p_pkg::X_W]),
      .log_val (lane_log),
      .neg_inf (lane_neg)
    );

    assign data_next[l*l2p_pkg::OUT_W +: l2p_pkg::OUT_W] = lane_log;
    assign user_next[l] = lane_neg;
  end

  if (l2p_pkg::OUT_DW > l2p_pkg::LANES * l2p_pkg::OUT_W) begin : g_pad
    assign data_next[l2p_pkg::OUT_DW-1:l2p_pkg::LANES*l2p_pkg::OUT_W] = '0;
  end

  // merging output register
  always_ff @(posedge clk) begin
    if (ctl.en[l2p_pkg::PIPE_DEPTH-1]) begin
      m_tdata <= data_next;
      m_tuser <= user_next;
    end
  end

endmodule

[rtl/l2p_ctrl.sv]
// l2p_ctrl: valid bits and ripple-back load enables of the pipeline.
// Depends on l2p_pkg.
module l2p_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  output l2p_pkg::pipe_ctl_t ctl
);

  logic [l2p_pkg::PIPE_DEPTH-1:0] vld;
  logic [l2p_pkg::PIPE_DEPTH-1:0] en;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    en[l2p_pkg::PIPE_DEPTH-1] = !vld[l2p_pkg::PIPE_DEPTH-1] || m_tready;
    for (int i = l2p_pkg::PIPE_DEPTH - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < l2p_pkg::PIPE_DEPTH; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign ctl.en   = en;
  assign s_tready = en[0];
  assign m_tvalid = vld[l2p_pkg::PIPE_DEPTH-1];

endmodule

[rtl/l2p_lane.sv]
// l2p_lane: one lane of the log2 datapath: decode, five Horner steps,
// final product with (m-1) and exponent add. Depends on l2p_pkg.
module l2p_lane (
  input  logic                              clk,
  input  l2p_pkg::pipe_ctl_t                ctl,
  input  logic [l2p_pkg::X_W-1:0]           x,
  output logic signed [l2p_pkg::OUT_W-1:0]  log_val,
  output logic                              neg_inf
);

  localparam int SIDE_N = l2p_pkg::LANE_STAGES - 1;
  localparam int FMUL_S = 2 * l2p_pkg::DEGREE + 1;
  localparam int FADD_S = FMUL_S + 1;

  // side data riding along with each stage
  logic [l2p_pkg::MANT_W-1:0]        frac_q [SIDE_N];
  logic signed [l2p_pkg::EXPO_W-1:0] expo_q [SIDE_N];
  logic                              neg_q  [SIDE_N];

  logic [l2p_pkg::EXP_W-1:0]  x_exp;
  logic [l2p_pkg::MANT_W-1:0] x_frac;
  logic                       x_nan;
  logic                       x_neg;

  // field split and zero-or-negative test
  always_comb begin
    x_exp  = x[l2p_pkg::X_W-2 -: l2p_pkg::EXP_W];
    x_frac = x[l2p_pkg::MANT_W-1:0];
    x_nan  = (x_exp == l2p_pkg::EXP_ALL_ONES) && (x_frac != '0);
    x_neg  = (x[l2p_pkg::X_W-2:0] == '0) || (x[l2p_pkg::X_W-1] && !x_nan);
  end

  // decode stage and side data shift line
  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      frac_q[0] <= x_frac;
      expo_q[0] <= $signed({1'b0, x_exp}) - l2p_pkg::EXPO_W'(l2p_pkg::EXP_BIAS);
      neg_q[0]  <= x_neg;
    end
    for (int s = 1; s < SIDE_N; s++) begin
      if (ctl.en[s]) begin
        frac_q[s] <= frac_q[s-1];
        expo_q[s] <= expo_q[s-1];
        neg_q[s]  <= neg_q[s-1];
      end
    end
  end

  logic signed [l2p_pkg::PROD_W-1:0] prod_q [l2p_pkg::DEGREE];
  logic signed [l2p_pkg::P_W-1:0]    p_q    [l2p_pkg::DEGREE];

  // horner steps: multiply by m, then round and add the next coefficient
  for (genvar j = 0; j < l2p_pkg::DEGREE; j++) begin : g_horner
    logic signed [l2p_pkg::P_W-1:0]    p_in;
    logic signed [l2p_pkg::M_W:0]      m_s;
    logic signed [l2p_pkg::PROD_W:0]   rnd;

    if (j == 0) begin : g_first
      assign p_in = l2p_pkg::coef(l2p_pkg::DEGREE);
    end else begin : g_next
      assign p_in = p_q[j-1];
    end

    assign m_s = $signed({2'b01, frac_q[2*j]});
    assign rnd = ((l2p_pkg::PROD_W+1)'(prod_q[j])
                  + ((l2p_pkg::PROD_W+1)'(1) <<< (l2p_pkg::MANT_W - 1)))
                 >>> l2p_pkg::MANT_W;

    always_ff @(posedge clk) begin
      if (ctl.en[2*j+1]) begin
        prod_q[j] <= m_s * p_in;
      end
      if (ctl.en[2*j+2]) begin
        p_q[j] <= l2p_pkg::P_W'(rnd) + l2p_pkg::coef(l2p_pkg::DEGREE - 1 - j);
      end
    end
  end

  logic signed [l2p_pkg::FPROD_W-1:0] fprod_q;
  logic signed [l2p_pkg::MANT_W:0]    frac_s;
  logic signed [l2p_pkg::FPROD_W:0]   frnd;
  logic signed [63:0]                 sum;

  // final term p*(m-1), rounded, plus the integer part
  always_comb begin
    frac_s = $signed({1'b0, frac_q[FMUL_S-1]});
    frnd   = ((l2p_pkg::FPROD_W+1)'(fprod_q)
              + ((l2p_pkg::FPROD_W+1)'(1) <<< (l2p_pkg::MANT_W - 1)))
             >>> l2p_pkg::MANT_W;
    sum    = 64'(frnd) + (64'(expo_q[FADD_S-1]) <<< l2p_pkg::FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (ctl.en[FMUL_S]) begin
      fprod_q <= p_q[l2p_pkg::DEGREE-1] * frac_s;
    end
    if (ctl.en[FADD_S]) begin
      log_val <= neg_q[FADD_S-1] ? '0 : sum[l2p_pkg::OUT_W-1:0];
      neg_inf <= neg_q[FADD_S-1];
    end
  end

endmodule

[rtl/l2p_checker.sv]
// l2p_checker: port-level checks of the log2 block, bound to the top level.
// Depends on l2p_pkg and log2_poly_approx_4lane.
module l2p_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [l2p_pkg::IN_DW-1:0]   s_tdata,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [l2p_pkg::OUT_DW-1:0]  m_tdata,
  input  logic [l2p_pkg::LANES-1:0]   m_tuser
);

  // stalled request keeps its valid
  a_hold_valid : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output valid dropped under stall");

  // stalled request keeps its payload
  a_hold_data : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("output payload changed under stall");

  // an empty output stage never blocks the input
  a_ready_empty : assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output is empty");

  // nothing comes out right after reset
  a_reset_clear : assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // a flagged lane gives a zero log
  for (genvar l = 0; l < l2p_pkg::LANES; l++) begin : g_lane_chk
    a_neg_zero : assert property (@(posedge clk) disable iff (rst)
      m_tvalid && m_tuser[l] |-> m_tdata[l*l2p_pkg::OUT_W +: l2p_pkg::OUT_W] == '0)
      else $error("flagged lane carries a nonzero log");
  end

endmodule

bind log2_poly_approx_4lane l2p_checker u_l2p_checker (.*);
